// ----- sv/lsf_pkg.sv -----
// types and constants shared by the line substring filter
package lsf_pkg;

   localparam int PAT_BYTES   = 31;
   localparam int PLEN_W      = 5;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [7:0] NEWLINE = 8'd10;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAT_0_7   = 3'd0,
      CSR_PAT_8_15  = 3'd1,
      CSR_PAT_16_23 = 3'd2,
      CSR_PAT_24_31 = 3'd3,
      CSR_PLEN      = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } lsf_state_type;

   typedef logic [PAT_BYTES-1:0][7:0] pattern_type;

   typedef struct packed {
      pattern_type        pattern;
      logic [PLEN_W-1:0]  plen;
      logic               update;
   } cfg_type;

   typedef struct packed {
      logic       clear;
      logic       step;
      logic [7:0] data;
   } match_ctl_type;

endpackage

// ----- sv/lsf_if.sv -----
// valid/ready channel interfaces for text input, line output and register writes
interface lsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
   modport mon    (input valid, input text_byte, input ready);
endinterface

interface lsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;
   logic       end_of_line;

   modport source (output valid, output line_byte, output end_of_line, input ready);
   modport sink   (input valid, input line_byte, input end_of_line, output ready);
   modport mon    (input valid, input line_byte, input end_of_line, input ready);
endinterface

interface lsf_csr_if;
   logic                               valid;
   logic                               ready;
   logic [lsf_pkg::CSR_INDEX_W-1:0]    index;
   logic [lsf_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
   modport mon    (input valid, input index, input data, input ready);
endinterface

// ----- sv/lsf_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
module lsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 62
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/lsf_cfg.sv -----
// pattern and pattern length registers behind the register write channel
module lsf_cfg #(
   parameter int PATTERN_MAX = 31
) (
   input  logic             clock,
   input  logic             reset,
   lsf_csr_if.sink          csr_ch,
   output lsf_pkg::cfg_type cfg
);
   import lsf_pkg::*;

   pattern_type       pat_ff;
   logic [PLEN_W-1:0] plen_ff;
   logic              update;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff  <= '0;
         plen_ff <= PLEN_W'(1);
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_PAT_0_7: begin
               for (int j = 0; j < 8; j++) pat_ff[j] <= csr_ch.data[8*j +: 8];
            end
            CSR_PAT_8_15: begin
               for (int j = 0; j < 8; j++) pat_ff[8+j] <= csr_ch.data[8*j +: 8];
            end
            CSR_PAT_16_23: begin
               for (int j = 0; j < 8; j++) pat_ff[16+j] <= csr_ch.data[8*j +: 8];
            end
            CSR_PAT_24_31: begin
               // top byte of this register has no pattern slot
               for (int j = 0; j < 7; j++) pat_ff[24+j] <= csr_ch.data[8*j +: 8];
            end
            CSR_PLEN: begin
               plen_ff <= csr_ch.data[PLEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index_type'(csr_ch.index))
         CSR_PAT_0_7, CSR_PAT_8_15, CSR_PAT_16_23, CSR_PAT_24_31, CSR_PLEN:
            update = csr_ch.valid;
         default:
            update = 1'b0;
      endcase
   end

   assign cfg = '{
      pattern: pat_ff,
      plen:    (plen_ff > PLEN_W'(PATTERN_MAX)) ? PLEN_W'(PATTERN_MAX) : plen_ff,
      update:  update
   };

endmodule

// ----- sv/lsf_match.sv -----
// shift-and matcher: one line byte per step, sticky found flag per line
module lsf_match #(
   parameter int PATTERN_MAX = 31
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lsf_pkg::match_ctl_type ctl,
   input  lsf_pkg::pattern_type   pattern,
   input  logic [lsf_pkg::PLEN_W-1:0] plen,
   output logic                   hit
);
   import lsf_pkg::*;

   logic [PATTERN_MAX-1:0] vec_ff;
   logic [PATTERN_MAX-1:0] vec_in;
   logic                   found_ff;
   logic                   step_hit;

   // bit k set: pattern bytes 0..k end at the current byte
   always_comb begin
      step_hit = 1'b0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         vec_in[k] = ((k == 0) ? 1'b1 : vec_ff[(k == 0) ? 0 : k-1])
                     & (ctl.data == pattern[k]);
         if (plen == PLEN_W'(k+1)) begin
            step_hit = vec_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         vec_ff   <= '0;
         found_ff <= 1'b0;
      end else if (ctl.step) begin
         vec_ff   <= vec_in;
         found_ff <= found_ff | step_hit;
      end
   end

   // the empty pattern is found in every line
   assign hit = found_ff || (plen == '0);

endmodule

// ----- sv/line_substring_filter.sv -----
// line substring filter top level: line store, matcher, control sequencer
// Text bytes are written into a line store ram at one transaction per cycle while the matcher
// follows the line as it arrives. A newline, or any byte that arrives while the store already
// holds LINE_MAX bytes, ends the line; that byte is dropped. If the pattern registers were not
// written since the previous line ended, the match decision is made in the same cycle; after a
// pattern or length write the store is rescanned once from the ram before the decision.
// A matching line is sent out from the ram one byte at a time, each read issued only when the
// output register will be free to take its registered data, and a new read waits until the
// previous byte is loaded. The bytes are followed by a newline with end_of_line set; no input
// is taken while a line is rescanned or sent. A non-matching line is dropped without leaving
// the idle state unless a rescan is due. The line store needs no clearing after reset.
module line_substring_filter #(
   parameter int LINE_MAX    = 62,
   parameter int PATTERN_MAX = 31
) (
   input  logic       clock,
   input  logic       reset,
   lsf_req_if.sink    req_ch,
   lsf_rsp_if.source  rsp_ch,
   lsf_csr_if.sink    csr_ch
);
   import lsf_pkg::*;

   localparam int FILL_W = $clog2(LINE_MAX + 1);
   localparam int ADDR_W = $clog2(LINE_MAX);

   lsf_state_type state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] rd_ff, rd_in;
   logic              pend_ff, pend_in;
   logic              stale_ff, stale_in;

   logic              outv_ff;
   logic [7:0]        obyte_ff;
   logic              oeol_ff;
   logic              load_data;
   logic              load_nl;
   logic              out_free;

   logic              ram_we;
   logic [7:0]        ram_rdata;
   logic              accept;
   logic              line_end;

   cfg_type           cfg;
   match_ctl_type     mctl;
   logic              hit;

   lsf_cfg #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   lsf_match #(.PATTERN_MAX(PATTERN_MAX)) u_match (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mctl),
      .pattern (cfg.pattern),
      .plen    (cfg.plen),
      .hit     (hit)
   );

   lsf_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (fill_ff[ADDR_W-1:0]),
      .wdata (req_ch.text_byte),
      .raddr (rd_ff[ADDR_W-1:0]),
      .rdata (ram_rdata)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign line_end     = (req_ch.text_byte == NEWLINE) || (fill_ff >= FILL_W'(LINE_MAX));
   assign out_free     = !outv_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         rd_ff    <= '0;
         pend_ff  <= 1'b0;
         stale_ff <= 1'b0;
         outv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         rd_ff    <= rd_in;
         pend_ff  <= pend_in;
         stale_ff <= stale_in;
         if (load_data || load_nl) begin
            outv_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            outv_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_data) begin
         obyte_ff <= ram_rdata;
         oeol_ff  <= 1'b0;
      end else if (load_nl) begin
         obyte_ff <= NEWLINE;
         oeol_ff  <= 1'b1;
      end
   end

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      rd_in      = rd_ff;
      pend_in    = 1'b0;
      stale_in   = stale_ff || cfg.update;
      ram_we     = 1'b0;
      load_data  = 1'b0;
      load_nl    = 1'b0;
      mctl.clear = 1'b0;
      mctl.step  = 1'b0;
      mctl.data  = req_ch.text_byte;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (line_end) begin
                  rd_in = '0;
                  if (stale_ff) begin
                     // pattern changed mid-line: search the store again
                     state_in   = ST_SCAN;
                     stale_in   = cfg.update;
                     mctl.clear = 1'b1;
                  end else if (hit) begin
                     state_in = ST_EMIT;
                  end else begin
                     fill_in    = '0;
                     mctl.clear = 1'b1;
                  end
               end else begin
                  ram_we    = 1'b1;
                  fill_in   = fill_ff + FILL_W'(1);
                  mctl.step = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (pend_ff) begin
               mctl.step = 1'b1;
               mctl.data = ram_rdata;
            end
            if (rd_ff < fill_ff) begin
               pend_in = 1'b1;
               rd_in   = rd_ff + FILL_W'(1);
            end else if (!pend_ff) begin
               rd_in = '0;
               if (hit) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in   = ST_IDLE;
                  fill_in    = '0;
                  mctl.clear = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            load_data = pend_ff;
            if (!pend_ff && out_free) begin
               if (rd_ff < fill_ff) begin
                  pend_in = 1'b1;
                  rd_in   = rd_ff + FILL_W'(1);
               end else begin
                  load_nl    = 1'b1;
                  state_in   = ST_IDLE;
                  fill_in    = '0;
                  mctl.clear = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid       = outv_ff;
   assign rsp_ch.line_byte   = obyte_ff;
   assign rsp_ch.end_of_line = oeol_ff;

endmodule

// ----- sv/lsf_checker.sv -----
// port-level checks on the line substring filter, bound to the top level
module lsf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_line_byte,
   input logic       rsp_end_of_line,
   input logic       csr_valid,
   input logic       csr_ready
);
   import lsf_pkg::*;

   // a held result keeps its payload until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_line_byte) && $stable(rsp_end_of_line))
      else $error("rsp payload changed while stalled");

   // nothing is offered right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // while line bytes are being sent no new text is taken
   a_no_input_mid_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_line |-> !req_ready)
      else $error("text accepted while a line is being sent");

   // the closing transaction is always a newline
   a_eol_newline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_line |-> rsp_line_byte == NEWLINE)
      else $error("end_of_line on a byte other than newline");

   // register writes are never stalled
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind line_substring_filter lsf_checker u_lsf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_line_byte   (rsp_ch.line_byte),
   .rsp_end_of_line (rsp_ch.end_of_line),
   .csr_valid       (csr_ch.valid),
   .csr_ready       (csr_ch.ready)
);

// ----- verif/tb_top.sv -----
// testbench for line_substring_filter: directed and random text checked against a line predictor
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lsf_pkg::*;

   localparam int LINE_MAX        = 62;
   localparam int ITEM_TARGET     = 420;
   localparam int SETTLE_CYCLES   = 100;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int QUIET_LIMIT     = 4000;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = CSR_INDEX_W'(CSR_PLEN + 1);

   typedef enum {LINE_HIT, LINE_RANDOM, LINE_OVERFLOW, LINE_NOISE} line_kind_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       end_of_line;
   } line_out_type;

   logic clock = 1'b0;
   logic reset;

   lsf_req_if req_if();
   lsf_rsp_if rsp_if();
   lsf_csr_if csr_if();

   line_substring_filter dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // predicted filter state
   logic [63:0]       pat_word [4];
   logic [PLEN_W-1:0] pat_len;
   logic [7:0]        line_bytes [LINE_MAX];
   int                line_fill;
   line_out_type      pending_line_out [$];

   int mismatch_count = 0;
   int text_count     = 0;
   bit text_live      = 1'b0;
   bit req_gaps       = 1'b0;
   bit rsp_stalls     = 1'b0;
   int hold_off_len   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] pattern_byte(input int k);
      return pat_word[k / 8][(k % 8) * 8 +: 8];
   endfunction

   function automatic bit line_has_pattern();
      int plen;
      bit hit;
      plen = int'(pat_len);
      if (plen > line_fill) return 1'b0;
      for (int s = 0; s + plen <= line_fill; s++) begin
         hit = 1'b1;
         for (int k = 0; k < plen; k++)
            if (line_bytes[s + k] != pattern_byte(k)) hit = 1'b0;
         if (hit) return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic filter_text_byte(input logic [7:0] b);
      line_out_type o;
      // a full store ends the line on any byte, which is then dropped
      if (b == NEWLINE || line_fill >= LINE_MAX) begin
         if (line_has_pattern()) begin
            for (int k = 0; k < line_fill; k++) begin
               o.line_byte   = line_bytes[k];
               o.end_of_line = 1'b0;
               pending_line_out.push_back(o);
            end
            o.line_byte   = NEWLINE;
            o.end_of_line = 1'b1;
            pending_line_out.push_back(o);
         end
         line_fill = 0;
      end else begin
         line_bytes[line_fill] = b;
         line_fill++;
      end
   endtask

   function automatic logic [7:0] pick_text_byte();
      logic [7:0] b;
      if (pat_len != 0 && $urandom_range(0, 1)) b = pattern_byte($urandom_range(0, pat_len - 1));
      else b = 8'($urandom_range(0, 255));
      if (b == NEWLINE) b = ~b;
      return b;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic send_text(input logic [7:0] b);
      int gap;
      gap = req_gaps ? pick_gap() : 0;
      if (!text_live) @(posedge clock);
      else if (gap != 0) req_if.valid <= 1'b0;
      repeat (gap) @(posedge clock);
      req_if.valid     <= 1'b1;
      req_if.text_byte <= b;
      text_live = 1'b1;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      text_count++;
      filter_text_byte(b);
   endtask

   // called in the step of the last acceptance so the stale byte is never taken again
   task automatic stop_text();
      if (text_live) begin
         req_if.valid <= 1'b0;
         text_live = 1'b0;
      end
   endtask

   task automatic send_bytes(input logic [7:0] text [$]);
      foreach (text[i]) send_text(text[i]);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      case (idx)
         CSR_PAT_0_7:   pat_word[0] = data;
         CSR_PAT_8_15:  pat_word[1] = data;
         CSR_PAT_16_23: pat_word[2] = data;
         CSR_PAT_24_31: pat_word[3] = data;
         CSR_PLEN:      pat_len = data[PLEN_W-1:0];
         default: ;
      endcase
      csr_if.valid <= 1'b0;
   endtask

   // wait out all predicted output plus a possible rescan of the store
   task automatic drain_lines();
      stop_text();
      while (pending_line_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_line(input line_kind_type kind);
      logic [7:0] body [LINE_MAX];
      logic [7:0] last;
      int len, at, plen;
      plen = int'(pat_len);
      last = NEWLINE;
      if (kind == LINE_OVERFLOW)
         len = $urandom_range(0, 1) ? LINE_MAX : $urandom_range(LINE_MAX - 4, LINE_MAX - 1);
      else if (kind == LINE_NOISE) len = $urandom_range(1, 8);
      else if ($urandom_range(0, 99) < 75) len = $urandom_range(0, 12);
      else len = $urandom_range(13, 40);
      if (kind == LINE_HIT && len < plen) len = plen;
      for (int k = 0; k < len; k++) begin
         body[k] = pick_text_byte();
         if (kind == LINE_NOISE && $urandom_range(0, 3) == 0) body[k] = NEWLINE;
      end
      if ((kind == LINE_HIT || (kind == LINE_OVERFLOW && $urandom_range(0, 1))) && len >= plen)
      begin
         at = $urandom_range(0, len - plen);
         for (int k = 0; k < plen; k++) body[at + k] = pattern_byte(k);
      end
      if (kind == LINE_OVERFLOW && len == LINE_MAX && $urandom_range(0, 1))
         last = 8'($urandom_range(0, 255));
      for (int k = 0; k < len; k++) send_text(body[k]);
      if (kind != LINE_NOISE) send_text(last);
   endtask

   // pattern after reset is a single zero byte
   task automatic test_reset_defaults();
      send_bytes('{NEWLINE});
      send_bytes('{8'h41, NEWLINE});
      send_bytes('{8'hFF, 8'h00, NEWLINE});
   endtask

   task automatic test_empty_pattern();
      logic [CSR_DATA_W-1:0] data;
      drain_lines();
      data = {$urandom(), $urandom()};
      data[CSR_DATA_W-1] = 1'b1;
      data[PLEN_W-1:0]   = '0;
      write_csr(CSR_PLEN, data);
      for (int i = int'(CSR_SPARE_FIRST); i < 2 ** CSR_INDEX_W; i++)
         write_csr(CSR_INDEX_W'(i), {$urandom(), $urandom()});
      send_bytes('{NEWLINE});
      send_bytes('{8'hFF, NEWLINE});
      send_bytes('{8'h00, 8'h7F, NEWLINE});
   endtask

   task automatic test_short_pattern();
      logic [CSR_DATA_W-1:0] data;
      drain_lines();
      data = {$urandom(), $urandom()};
      data[23:0] = 24'h00FF61;
      write_csr(CSR_PAT_0_7, data);
      data = {$urandom(), $urandom()};
      data[PLEN_W-1:0] = 5'd3;
      write_csr(CSR_PLEN, data);
      // line shorter than the pattern, overlapping false start, near miss
      send_bytes('{8'h61, 8'hFF, NEWLINE});
      send_bytes('{8'h7E, 8'h61, 8'hFF, 8'h61, 8'hFF, 8'h00, NEWLINE});
      send_bytes('{8'h61, 8'hFF, 8'h01, NEWLINE});
   endtask

   task automatic test_output_backpressure();
      logic [CSR_DATA_W-1:0] data;
      drain_lines();
      data = {$urandom(), $urandom()};
      data[7:0] = 8'h78;
      write_csr(CSR_PAT_0_7, data);
      data = {$urandom(), $urandom()};
      data[PLEN_W-1:0] = 5'd1;
      write_csr(CSR_PLEN, data);
      req_gaps     = 1'b0;
      hold_off_len = HOLD_OFF_CYCLES;
      repeat (4) send_line(LINE_HIT);
      drain_lines();
   endtask

   task automatic test_random_text();
      logic [63:0]           w [4];
      logic [7:0]            b;
      logic [CSR_DATA_W-1:0] data;
      int phase, roll, n;
      phase = 0;
      while (text_count < ITEM_TARGET) begin
         // leave part of a line in the store so the new pattern covers bytes already taken
         if ($urandom_range(0, 1))
            repeat ($urandom_range(1, 20)) send_text(pick_text_byte());
         drain_lines();
         for (int k = 0; k < 4; k++)
            for (int j = 0; j < 8; j++) begin
               b = 8'($urandom_range(0, 255));
               if (b == NEWLINE && phase % 4 != 3) b = ~b;
               w[k][j * 8 +: 8] = b;
            end
         case (phase)
            0: begin
               w[0] = '1; w[1] = '1; w[2] = '1; w[3] = '1;
               n = PAT_BYTES;
            end
            1: n = 0;
            2: begin
               w[0] = '0;
               n = 1;
            end
            3: n = PAT_BYTES;
            default: n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 4)
                                                     : $urandom_range(5, PAT_BYTES);
         endcase
         write_csr(CSR_PAT_0_7, w[0]);
         write_csr(CSR_PAT_8_15, w[1]);
         write_csr(CSR_PAT_16_23, w[2]);
         write_csr(CSR_PAT_24_31, w[3]);
         data = {$urandom(), $urandom()};
         data[PLEN_W-1:0] = PLEN_W'(n);
         write_csr(CSR_PLEN, data);
         req_gaps   = $urandom_range(0, 3) != 0;
         rsp_stalls = $urandom_range(0, 3) != 0;
         repeat ($urandom_range(4, 8)) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) send_line(LINE_HIT);
            else if (roll < 77) send_line(LINE_RANDOM);
            else if (roll < 89) send_line(LINE_OVERFLOW);
            else send_line(LINE_NOISE);
         end
         phase++;
      end
   endtask

   always @(posedge clock) begin
      line_out_type exp_out;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_line_out.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction, line_byte %02h end_of_line %0b",
                                      rsp_if.line_byte, rsp_if.end_of_line));
         end else begin
            exp_out = pending_line_out.pop_front();
            if (rsp_if.line_byte !== exp_out.line_byte)
               report_mismatch($sformatf("line_byte %02h, expected %02h",
                                         rsp_if.line_byte, exp_out.line_byte));
            if (rsp_if.end_of_line !== exp_out.end_of_line)
               report_mismatch($sformatf("end_of_line %0b, expected %0b on byte %02h",
                                         rsp_if.end_of_line, exp_out.end_of_line,
                                         exp_out.line_byte));
         end
      end
   end

   initial begin : line_receiver
      int stall;
      rsp_if.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_len != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold_off_len) @(posedge clock);
            hold_off_len = 0;
         end else if (rsp_stalls && $urandom_range(0, 99) < 25) begin
            stall = pick_gap() + 1;
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
             (csr_if.valid === 1'b1 && csr_if.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout after %0d quiet cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin : run
      req_if.valid     <= 1'b0;
      req_if.text_byte <= '0;
      csr_if.valid     <= 1'b0;
      csr_if.index     <= '0;
      csr_if.data      <= '0;
      reset            <= 1'b1;
      pat_word[0] = '0;
      pat_word[1] = '0;
      pat_word[2] = '0;
      pat_word[3] = '0;
      pat_len     = 5'd1;
      line_fill   = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_empty_pattern();
      test_short_pattern();
      test_output_backpressure();
      test_random_text();
      drain_lines();
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
